// File: sv/lkh_pkg.sv
// shared types, constants and reset values for the link keep-alive block
package lkh_pkg;

	localparam int TIMER_WIDTH_DEF = 16;

	localparam logic [15:0] CTRL_MAGIC   = 16'h4E4C;
	localparam logic [7:0]  CTRL_VERSION = 8'd1;
	localparam logic [7:0]  CTRL_LENGTH  = 8'd6;

	localparam logic [7:0] KIND_HELLO     = 8'd1;
	localparam logic [7:0] KIND_HELLO_ACK = 8'd2;
	localparam logic [7:0] KIND_HEARTBEAT = 8'd3;

	localparam logic [1:0] SEND_NONE      = 2'd0;
	localparam logic [1:0] SEND_HELLO     = 2'd1;
	localparam logic [1:0] SEND_HELLO_ACK = 2'd2;
	localparam logic [1:0] SEND_HEARTBEAT = 2'd3;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam logic [1:0] CFG_PEER_ADDRESS     = 2'd0;
	localparam logic [1:0] CFG_HEARTBEAT_PERIOD = 2'd1;
	localparam logic [1:0] CFG_LINK_TIMEOUT     = 2'd2;

	localparam logic [47:0] PEER_ADDRESS_RST     = 48'd0;
	localparam logic [15:0] HEARTBEAT_PERIOD_RST = 16'd500;
	localparam logic [15:0] LINK_TIMEOUT_RST     = 16'd3000;

	typedef struct packed {
		logic        op;
		logic [47:0] source_address;
		logic [7:0]  packet_length;
		logic [15:0] frame_magic;
		logic [7:0]  frame_version;
		logic [7:0]  frame_kind;
	} in_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [1:0]  send_kind;
		logic [15:0] send_sequence;
		logic        connected;
		logic        state_changed;
		logic        forward_payload;
	} out_item_t;

	typedef struct packed {
		logic [47:0] peer_address;
		logic [15:0] heartbeat_period;
		logic [15:0] link_timeout;
	} cfg_t;

endpackage

// File: sv/lkh_cfg_regs.sv
// configuration register file of the link keep-alive block
module lkh_cfg_regs import lkh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peer_address     <= PEER_ADDRESS_RST;
			cfg_q.heartbeat_period <= HEARTBEAT_PERIOD_RST;
			cfg_q.link_timeout     <= LINK_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PEER_ADDRESS:     cfg_q.peer_address     <= cfg_data;
				CFG_HEARTBEAT_PERIOD: cfg_q.heartbeat_period <= cfg_data[15:0];
				CFG_LINK_TIMEOUT:     cfg_q.link_timeout     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

// File: sv/lkh_engine.sv
// link state, sequence counter, timers and the per-item decision logic
module lkh_engine import lkh_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	logic                   link_up_q, link_up_n;
	logic [15:0]            seq_q, seq_n;
	logic [TIMER_WIDTH-1:0] tx_q, tx_n, tx_inc;
	logic [TIMER_WIDTH-1:0] rx_q, rx_n, rx_inc;
	logic                   ctrl_ok;

	// saturating timers
	assign tx_inc = (tx_q == '1) ? tx_q : tx_q + 1'b1;
	assign rx_inc = (rx_q == '1) ? rx_q : rx_q + 1'b1;

	always_comb begin
		ctrl_ok = (item.packet_length == CTRL_LENGTH) &&
			(item.frame_magic == CTRL_MAGIC) &&
			(item.frame_version == CTRL_VERSION) &&
			(item.frame_kind inside {KIND_HELLO, KIND_HELLO_ACK, KIND_HEARTBEAT});

		link_up_n = link_up_q;
		seq_n     = seq_q;
		tx_n      = tx_q;
		rx_n      = rx_q;
		res       = '0;

		if (item.op == OP_PACKET) begin
			if (item.source_address == cfg.peer_address) begin
				if (item.packet_length != CTRL_LENGTH) begin
					res.forward_payload = 1'b1;
				end else if (ctrl_ok) begin
					rx_n      = '0;
					link_up_n = 1'b1;
					if (item.frame_kind == KIND_HELLO) begin
						seq_n             = seq_q + 16'd1;
						res.send_valid    = 1'b1;
						res.send_kind     = SEND_HELLO_ACK;
						res.send_sequence = seq_n;
					end
				end
			end
		end else begin
			tx_n = tx_inc;
			rx_n = rx_inc;
			if (CMP_W'(tx_inc) >= CMP_W'(cfg.heartbeat_period)) begin
				seq_n             = seq_q + 16'd1;
				tx_n              = '0;
				res.send_valid    = 1'b1;
				res.send_kind     = link_up_q ? SEND_HEARTBEAT : SEND_HELLO;
				res.send_sequence = seq_n;
			end
			// timeout check sees the link state before this tick's send
			if (link_up_q && (CMP_W'(rx_inc) >= CMP_W'(cfg.link_timeout))) begin
				link_up_n = 1'b0;
			end
		end

		res.connected     = link_up_n;
		res.state_changed = link_up_n != link_up_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_up_q <= 1'b0;
			seq_q     <= '0;
			tx_q      <= '1;
			rx_q      <= '0;
		end else if (fire) begin
			link_up_q <= link_up_n;
			seq_q     <= seq_n;
			tx_q      <= tx_n;
			rx_q      <= rx_n;
		end
	end

	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.send_valid |=> seq_q == $past(seq_q) + 16'd1)
		else $error("sequence number did not step on a send");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(seq_q) && $stable(link_up_q) && $stable(tx_q) && $stable(rx_q))
		else $error("state moved without a transaction");

	a_packet_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_PACKET |=> $stable(tx_q))
		else $error("packet touched the transmit timer");

	a_tick_tx_live: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_TICK && !res.send_valid |=> tx_q != '0)
		else $error("transmit timer cleared without a send");

	a_send_or_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(res.send_valid && res.forward_payload))
		else $error("send and forward on the same item");

endmodule

// File: sv/link_keepalive_handshake.sv
// top level of the link keep-alive block: input stage, config registers, engine, result register
//
// channel  signals                                    direction
// in       in_valid, in_ready, in_data (in_item_t)    item in
// out      out_valid, out_ready, out_data (out_item_t) result out
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register write in
//
// one item per cycle sustained while out_ready is high; a result is offered once its item
// has been held in the input register and the engine logic has loaded the result register
// reset clears link state, sequence count, receive timer and all valid flags;
// the transmit timer resets saturated so the first tick sends at once
// with out_ready low the result holds and one more item waits in the input stage
module link_keepalive_handshake import lkh_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t out_q;
	logic      out_valid_q;
	logic      adv;
	logic      fire;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	lkh_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lkh_engine #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			out_q <= res;
		end
	end

endmodule
